/* design/stop_and_wait_relay_two_port_macros.svh */
// Assertion macros for the stop-and-wait relay.
// Used by the top level; expects i_clk and i_rst_n in scope at the use site.
`ifndef STOP_AND_WAIT_RELAY_TWO_PORT_MACROS_SVH
`define STOP_AND_WAIT_RELAY_TWO_PORT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SAWR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sawr: same-cycle check failed");

// Next-cycle implication
`define SAWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sawr: next-cycle check failed");

`endif

/* design/sawr_pkg.sv */
// Shared types and codes for the stop-and-wait relay.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package sawr_pkg;

    localparam int NUM_PORTS  = 2;
    localparam int ID_FIELD_W = 16;
    localparam int DRAW_W     = 16;
    localparam int THR_W      = 17;

    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    // packet kind codes, on input and on output
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_NAK    = 2'd2;
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    typedef struct packed {
        logic                  arrival_port;
        logic [1:0]            op;
        logic                  from_source;
        logic                  bit_error;
        logic [ID_FIELD_W-1:0] packet_id;
        logic [DRAW_W-1:0]     random_draw;
        logic [NUM_PORTS-1:0]  port_busy;
    } t_in_beat;

    typedef struct packed {
        logic                  out_port;
        logic [1:0]            out_kind;
        logic [ID_FIELD_W-1:0] out_packet_id;
        logic                  last;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DATA
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_data;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_data;
    } t_dp_status;

endpackage

/* design/sawr_ctrl.sv */
// Sequencer for the stop-and-wait relay: accept, execute, optional second beat.
// Depends on sawr_pkg.
`timescale 1ns / 1ps

module sawr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sawr_pkg::t_dp_status i_status,
    output sawr_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import sawr_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_data ? S_DATA : S_IDLE;
            end
            S_DATA: begin
                o_cmd.load_data = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/sawr_datapath.sv */
// Datapath: input capture, routing, per-port handle queues, result register.
// Depends on sawr_pkg; driven by sawr_ctrl.
`timescale 1ns / 1ps

module sawr_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [sawr_pkg::THR_W-1:0] i_cfg_wdata,
    input  sawr_pkg::t_in_beat   i_item,
    input  sawr_pkg::t_dp_cmd    i_cmd,
    output sawr_pkg::t_dp_status o_status,
    output sawr_pkg::t_out_beat  o_result,
    output logic                 o_strobe
);
    import sawr_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int STORE_W = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;

    logic [THR_W-1:0]   r_thr;
    t_in_beat           r_item;
    logic [IDX_W-1:0]   r_head  [NUM_PORTS];
    logic [IDX_W-1:0]   n_head  [NUM_PORTS];
    logic [CNT_W-1:0]   r_count [NUM_PORTS];
    logic [CNT_W-1:0]   n_count [NUM_PORTS];
    logic [STORE_W-1:0] r_mem   [NUM_PORTS][QUEUE_DEPTH];
    logic [STORE_W-1:0] r_rdata;
    t_out_beat          r_out;
    logic               r_strobe;

    logic               route_port;
    logic               arr_port;
    logic               is_reply;
    logic               is_fwd;
    logic               is_ack;
    logic               is_nak;
    logic [CNT_W-1:0]   f_cnt;
    logic [IDX_W-1:0]   f_head;
    logic               full;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail;
    logic [CNT_W-1:0]   a_cnt;
    logic [IDX_W-1:0]   a_head;
    logic [IDX_W-1:0]   a_head_next;
    logic               fwd_ok;
    logic               fwd_send;
    logic               ack_pop;
    logic               ack_send;
    logic               nak_send;
    logic               send_data;
    logic               from_mem;
    logic [IDX_W-1:0]   rd_idx;
    t_out_beat          reply_beat;
    t_out_beat          data_beat;

    // routing threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // decode of the captured packet
    always_comb begin
        route_port = (THR_W'(r_item.random_draw) < r_thr) ? 1'b0 : 1'b1;
        arr_port   = r_item.arrival_port;
        is_reply   = !r_item.from_source && (r_item.op == OP_DATA);
        is_fwd     = r_item.from_source || (is_reply && !r_item.bit_error);
        is_ack     = !r_item.from_source && (r_item.op == OP_ACK);
        is_nak     = !r_item.from_source && (r_item.op != OP_DATA) && (r_item.op != OP_ACK);
    end

    // queue arithmetic: tail slot on the routed port, head advance on the arrival port
    always_comb begin
        f_cnt    = r_count[route_port];
        f_head   = r_head[route_port];
        full     = (f_cnt == CNT_W'(QUEUE_DEPTH));
        tail_sum = SUM_W'(f_head) + SUM_W'(f_cnt);
        tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

        a_cnt       = r_count[arr_port];
        a_head      = r_head[arr_port];
        a_head_next = (a_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : a_head + IDX_W'(1);

        fwd_ok   = is_fwd && !full;
        fwd_send = fwd_ok && (f_cnt == '0) && !r_item.port_busy[route_port];
        ack_pop  = is_ack && (a_cnt != '0);
        ack_send = ack_pop && (a_cnt != CNT_W'(1)) && !r_item.port_busy[arr_port];
        nak_send = is_nak && (a_cnt != '0) && !r_item.port_busy[arr_port];

        send_data = fwd_send || ack_send || nak_send;
        from_mem  = is_ack || is_nak;
        rd_idx    = is_ack ? a_head_next : a_head;

        o_status.need_data = send_data && (is_reply || from_mem);
    end

    // result beats
    always_comb begin
        reply_beat.out_port      = arr_port;
        reply_beat.out_kind      = r_item.bit_error ? KIND_NAK : KIND_ACK;
        reply_beat.out_packet_id = '0;
        reply_beat.last          = !send_data;

        data_beat.out_port      = from_mem ? arr_port : route_port;
        data_beat.out_kind      = KIND_DATA;
        data_beat.out_packet_id = from_mem ? ID_FIELD_W'(r_rdata) :
                                  ID_FIELD_W'(r_item.packet_id[STORE_W-1:0]);
        data_beat.last          = 1'b1;
    end

    // head and count update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.exec) begin
            if (fwd_ok) begin
                n_count[route_port] = f_cnt + CNT_W'(1);
            end
            if (ack_pop) begin
                n_head[arr_port]  = a_head_next;
                n_count[arr_port] = a_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_head[p]  <= '0;
                r_count[p] <= '0;
            end
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // handle memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && fwd_ok) begin
            r_mem[route_port][tail] <= r_item.packet_id[STORE_W-1:0];
        end
        r_rdata <= r_mem[arr_port][rd_idx];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else if (i_cmd.exec) begin
            r_strobe <= is_reply || (send_data && !from_mem);
        end else begin
            r_strobe <= i_cmd.load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= is_reply ? reply_beat : data_beat;
        end else if (i_cmd.load_data) begin
            r_out <= data_beat;
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule

/* design/stop_and_wait_relay_two_port.sv */
// Top level of the two-port stop-and-wait relay: controller plus datapath.
// Depends on sawr_pkg, sawr_ctrl, sawr_datapath and the assertion macro header.
//
//   channel   handshake           payload
//   -------   ---------           -------
//   item      start / busy        i_item   (t_in_beat)
//   result    o_strobe            o_result (t_out_beat), one cycle, no stall
//   config    i_cfg_we            i_cfg_wdata (route threshold)
//
// busy rises on the accepting edge and stays high through the execute state, and
// through the data state as well when a second beat follows or a handle must
// come from the queue memory (its read port is registered).
// Result beats leave the output register the cycle after they are formed.
// Reset (synchronous) empties both queues; the handle memory needs no clearing.
`timescale 1ns / 1ps
`include "stop_and_wait_relay_two_port_macros.svh"

module stop_and_wait_relay_two_port #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sawr_pkg::t_in_beat         i_item,
    input  logic                       i_cfg_we,
    input  logic [sawr_pkg::THR_W-1:0] i_cfg_wdata,
    output sawr_pkg::t_out_beat        o_result,
    output logic                       o_strobe
);
    import sawr_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    sawr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // queues and result register
    sawr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    // an accepted item holds the block busy for its execute cycle
    `SAWR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && dp_cmd.exec)
    // a beat not marked last is always followed directly by the closing beat
    `SAWR_ASSERT_NEXT(a_pair_back_to_back, o_strobe && !o_result.last, o_strobe && o_result.last)
    // replies carry no handle
    `SAWR_ASSERT_NOW(a_reply_no_id, o_strobe && (o_result.out_kind != KIND_DATA), o_result.out_packet_id == '0)

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the two-port stop-and-wait relay.
// Needs sawr_pkg and the stop_and_wait_relay_two_port RTL; reads no files.
`timescale 1ns / 1ps

module tb;
    import sawr_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int RAND_PER_PHASE = 253;
    localparam int NUM_PHASES     = 6;
    localparam int CALM_PHASE     = 2;    // phase run with no sender gaps
    localparam int IDLE_PCT       = 23;
    localparam int SETTLE_CYCLES  = 8;

    // op code 3 is unassigned; the relay treats it as a NAK
    localparam logic [1:0] OP_RSVD = 2'd3;
    localparam t_out_beat  NO_BEAT = '0;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_beat            i_item;
    logic                i_cfg_we;
    logic [THR_W-1:0]    i_cfg_wdata;
    t_out_beat           o_result;
    logic                o_strobe;

    stop_and_wait_relay_two_port dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the relay hangs
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Relay predictor: route threshold, per-port handle FIFOs
    // ------------------------------------------------------------------
    logic [THR_W-1:0]      thr_q;
    logic [ID_FIELD_W-1:0] hq_store [NUM_PORTS][QDEPTH];
    logic [3:0]            hq_head  [NUM_PORTS];
    logic [4:0]            hq_count [NUM_PORTS];

    // replies formed for the beat just accepted
    int                    reply_n;
    t_out_beat             reply_beats [2];

    t_out_beat             pending_replies [$];
    int                    fail_cnt = 0;

    function automatic void reply_add(logic port, logic [1:0] kind,
                                      logic [ID_FIELD_W-1:0] id);
        reply_beats[reply_n] = '{out_port: port, out_kind: kind,
                                 out_packet_id: id, last: 1'b0};
        reply_n++;
    endfunction

    // head of a FIFO goes out only when present and the channel is free
    function automatic void head_send(logic port, logic [NUM_PORTS-1:0] busy_bits);
        if (hq_count[port] != 0 && !busy_bits[port])
            reply_add(port, KIND_DATA, hq_store[port][hq_head[port]]);
    endfunction

    function automatic void route_new(logic [ID_FIELD_W-1:0] id, logic [DRAW_W-1:0] draw,
                                      logic [NUM_PORTS-1:0] busy_bits);
        logic       p;
        logic [3:0] tail;
        p = ({1'b0, draw} < thr_q) ? 1'b0 : 1'b1;
        if (hq_count[p] >= QDEPTH)
            return;     // full: dropped
        tail = hq_head[p] + hq_count[p][3:0];
        hq_store[p][tail] = id;
        hq_count[p]++;
        if (hq_count[p] == 5'd1)
            head_send(p, busy_bits);
    endfunction

    function automatic void relay_predict(t_in_beat b);
        reply_n = 0;
        if (b.from_source) begin
            route_new(b.packet_id, b.random_draw, b.port_busy);
        end else if (b.op == OP_DATA) begin
            if (b.bit_error) begin
                reply_add(b.arrival_port, KIND_NAK, '0);
            end else begin
                reply_add(b.arrival_port, KIND_ACK, '0);
                route_new(b.packet_id, b.random_draw, b.port_busy);
            end
        end else if (b.op == OP_ACK) begin
            if (hq_count[b.arrival_port] != 0) begin
                hq_head[b.arrival_port]++;
                hq_count[b.arrival_port]--;
                head_send(b.arrival_port, b.port_busy);
            end
        end else begin
            // NAK and the reserved code both resend the head
            head_send(b.arrival_port, b.port_busy);
        end
        if (reply_n > 0)
            reply_beats[reply_n-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: no back-pressure, every strobe is a beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_strobe) begin
            if (pending_replies.size() == 0) begin
                fail_cnt++;
                $error("unexpected result beat: port %0d kind %0d id %h",
                       o_result.out_port, o_result.out_kind, o_result.out_packet_id);
            end else begin
                want = pending_replies.pop_front();
                if (o_result.out_port !== want.out_port) begin
                    fail_cnt++;
                    $error("out_port: expected %0d, got %0d",
                           want.out_port, o_result.out_port);
                end
                if (o_result.out_kind !== want.out_kind) begin
                    fail_cnt++;
                    $error("out_kind: expected %0d, got %0d",
                           want.out_kind, o_result.out_kind);
                end
                if (o_result.out_packet_id !== want.out_packet_id) begin
                    fail_cnt++;
                    $error("out_packet_id: expected %h, got %h",
                           want.out_packet_id, o_result.out_packet_id);
                end
                if (o_result.last !== want.last) begin
                    fail_cnt++;
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // hold the beat until it is taken, then predict its replies
    task automatic issue_item(t_in_beat b);
        i_item <= b;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        relay_predict(b);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // threshold write, only with the relay quiet
    task automatic set_threshold(logic [THR_W-1:0] v);
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_q = v;
        @(posedge i_clk);
    endtask

    // random traffic: mostly sensible ARQ exchanges, some noise
    function automatic t_in_beat roll_beat();
        t_in_beat b;
        int       pick;
        b.arrival_port = 1'($urandom_range(0, 1));
        b.packet_id    = 16'($urandom_range(0, 65535));
        b.random_draw  = 16'($urandom_range(0, 65535));
        b.port_busy    = {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
        b.from_source  = 1'b0;
        b.bit_error    = 1'b0;
        b.op           = OP_DATA;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            b.from_source = 1'b1;
            b.op          = 2'($urandom_range(0, 3));
            b.bit_error   = 1'($urandom_range(0, 1));
        end else if (pick < 55) begin
            b.op = OP_DATA;
        end else if (pick < 65) begin
            b.bit_error = 1'b1;
        end else begin
            if (pick < 85)
                b.op = OP_ACK;
            else if (pick < 95)
                b.op = OP_NAK;
            else
                b.op = OP_RSVD;
            // steer most replies to a port with something outstanding
            if (hq_count[b.arrival_port] == 0 && $urandom_range(0, 3) != 0)
                b.arrival_port = ~b.arrival_port;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Directed table (threshold at reset value: draw < 0x8000 picks port 0)
    // ------------------------------------------------------------------
    typedef struct packed {
        t_in_beat   beat;
        logic [4:0] reps;
        logic       typed;      // expectations below, else predictor
        logic [1:0] n_typed;
        t_out_beat  exp_a;
        t_out_beat  exp_b;
    } t_dir_row;

    localparam int DIR_ROWS = 19;

    // beat fields: arrival_port, op, from_source, bit_error, id, draw, busy
    t_dir_row dir_table [DIR_ROWS] = '{
        // ACK with nothing outstanding
        '{'{1'b0, OP_ACK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd0,
          NO_BEAT, NO_BEAT},
        // NAK with nothing outstanding
        '{'{1'b1, OP_NAK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd0,
          NO_BEAT, NO_BEAT},
        // source packet, max id, lowest draw: straight out on port 0
        '{'{1'b0, OP_DATA, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd1,
          '{1'b0, KIND_DATA, 16'hFFFF, 1'b1}, NO_BEAT},
        // source packet with junk op/error, max draw: port 1, held while busy
        '{'{1'b1, OP_RSVD, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 2'b10}, 5'd1, 1'b1, 2'd0,
          NO_BEAT, NO_BEAT},
        // NAK on port 1 resends the held head
        '{'{1'b1, OP_NAK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b01}, 5'd1, 1'b1, 2'd1,
          '{1'b1, KIND_DATA, 16'h0000, 1'b1}, NO_BEAT},
        // good data: ACK ignores busy, forward queues behind port 0 head
        '{'{1'b1, OP_DATA, 1'b0, 1'b0, 16'h1234, 16'h7FFF, 2'b11}, 5'd1, 1'b1, 2'd1,
          '{1'b1, KIND_ACK, 16'h0000, 1'b1}, NO_BEAT},
        // corrupted data: NAK only, even when busy
        '{'{1'b0, OP_DATA, 1'b0, 1'b1, 16'hCAFE, 16'h0000, 2'b11}, 5'd1, 1'b1, 2'd1,
          '{1'b0, KIND_NAK, 16'h0000, 1'b1}, NO_BEAT},
        // ACK pops port 0, next head goes out
        '{'{1'b0, OP_ACK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b10}, 5'd1, 1'b1, 2'd1,
          '{1'b0, KIND_DATA, 16'h1234, 1'b1}, NO_BEAT},
        // ACK empties port 0
        '{'{1'b0, OP_ACK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b01}, 5'd1, 1'b1, 2'd0,
          NO_BEAT, NO_BEAT},
        // good data routed to port 1 behind its head
        '{'{1'b0, OP_DATA, 1'b0, 1'b0, 16'hA5A5, 16'h8000, 2'b00}, 5'd1, 1'b1, 2'd1,
          '{1'b0, KIND_ACK, 16'h0000, 1'b1}, NO_BEAT},
        // ACK on port 1 sends the new head
        '{'{1'b1, OP_ACK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd1,
          '{1'b1, KIND_DATA, 16'hA5A5, 1'b1}, NO_BEAT},
        // reserved op acts as NAK
        '{'{1'b1, OP_RSVD, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd1,
          '{1'b1, KIND_DATA, 16'hA5A5, 1'b1}, NO_BEAT},
        // good data to an empty free port: ACK then the packet
        '{'{1'b0, OP_DATA, 1'b0, 1'b0, 16'h5A5A, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd2,
          '{1'b0, KIND_ACK, 16'h0000, 1'b0}, '{1'b0, KIND_DATA, 16'h5A5A, 1'b1}},
        // fill port 0 to the brim
        '{'{1'b0, OP_DATA, 1'b1, 1'b0, 16'h0F0F, 16'h0001, 2'b00}, 5'd15, 1'b0, 2'd0,
          NO_BEAT, NO_BEAT},
        // full queue: ACK still returned, packet dropped
        '{'{1'b1, OP_DATA, 1'b0, 1'b0, 16'hBEEF, 16'h0000, 2'b00}, 5'd1, 1'b1, 2'd1,
          '{1'b1, KIND_ACK, 16'h0000, 1'b1}, NO_BEAT},
        // full queue: source packet dropped
        '{'{1'b0, OP_DATA, 1'b1, 1'b0, 16'h7777, 16'h0000, 2'b00}, 5'd1, 1'b0, 2'd0,
          NO_BEAT, NO_BEAT},
        // NAK while port 0 is busy: nothing
        '{'{1'b0, OP_NAK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b11}, 5'd1, 1'b1, 2'd0,
          NO_BEAT, NO_BEAT},
        // NAK with port 0 free resends its head
        '{'{1'b0, OP_NAK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b10}, 5'd1, 1'b0, 2'd0,
          NO_BEAT, NO_BEAT},
        // ACK empties port 1 while busy
        '{'{1'b1, OP_ACK,  1'b0, 1'b0, 16'h0000, 16'h0000, 2'b10}, 5'd1, 1'b1, 2'd0,
          NO_BEAT, NO_BEAT}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int               r;
        int               k;
        int               ph;
        int               taken;
        bit               ignored;
        t_in_beat         b;
        logic [THR_W-1:0] thr_list [NUM_PHASES];

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;

        thr_q = THR_RESET;
        for (int p = 0; p < NUM_PORTS; p++) begin
            hq_head[p]  = '0;
            hq_count[p] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (r = 0; r < DIR_ROWS; r++) begin
            for (k = 0; k < dir_table[r].reps; k++) begin
                issue_item(dir_table[r].beat);
                if (dir_table[r].typed) begin
                    if (dir_table[r].n_typed > 0)
                        pending_replies.push_back(dir_table[r].exp_a);
                    if (dir_table[r].n_typed > 1)
                        pending_replies.push_back(dir_table[r].exp_b);
                end else begin
                    for (int j = 0; j < reply_n; j++)
                        pending_replies.push_back(reply_beats[j]);
                end
                maybe_idle(1'b1);
            end
        end

        // random phases across threshold settings, extremes included
        thr_list = '{17'd0, 17'd65536, 17'd1, 17'd65535,
                     17'($urandom_range(0, 65536)), THR_RESET};
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_threshold(thr_list[ph]);
            taken = 0;
            while (taken < RAND_PER_PHASE) begin
                b = roll_beat();
                ignored = !b.from_source && b.op != OP_DATA
                          && hq_count[b.arrival_port] == 0;
                issue_item(b);
                for (int j = 0; j < reply_n; j++)
                    pending_replies.push_back(reply_beats[j]);
                if (!ignored)
                    taken++;
                maybe_idle(ph != CALM_PHASE);
            end
        end

        drain_replies();
        repeat (SETTLE_CYCLES + 2) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            fail_cnt++;
            $error("%0d result beats never arrived", pending_replies.size());
        end
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
